// ===== design/stc_pkg.sv =====
package stc_pkg;

  localparam int ENTRIES_DEF   = 256;
  localparam int KEY_WIDTH_DEF = 32;

  localparam int OPCODE_W = 3;
  localparam int FIELD_W  = 32;
  localparam int OCC_W    = 9;

  localparam logic [OPCODE_W-1:0] OP_ADD      = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_REMOVE   = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_REPLACE  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_CONTAINS = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_CLEAR    = 3'd4;

  typedef struct packed {
    logic                valid;
    logic [OPCODE_W-1:0] opcode;
    logic                done;
    logic                hit;
  } ctl_t;

endpackage

// ===== design/stc_cell.sv =====
module stc_cell #(
  parameter int KEY_WIDTH = stc_pkg::KEY_WIDTH_DEF,
  parameter int CNT_W     = 9
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  stc_pkg::ctl_t        ctl_i,
  input  logic [KEY_WIDTH-1:0] key_i,
  input  logic [KEY_WIDTH-1:0] nv_i,
  input  logic [CNT_W-1:0]     cnt_i,
  output stc_pkg::ctl_t        ctl_o,
  output logic [KEY_WIDTH-1:0] key_o,
  output logic [KEY_WIDTH-1:0] nv_o,
  output logic [CNT_W-1:0]     cnt_o
);

  logic [KEY_WIDTH-1:0] slot_r;
  logic [KEY_WIDTH-1:0] slot_nxt;
  stc_pkg::ctl_t        ctl_r;
  stc_pkg::ctl_t        ctl_nxt;
  logic [KEY_WIDTH-1:0] key_r;
  logic [KEY_WIDTH-1:0] nv_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [CNT_W-1:0]     cnt_nxt;
  logic                 match;
  logic                 free;

  assign match = (slot_r == key_i);
  assign free  = (slot_r == '0);

  always_comb begin
    slot_nxt = slot_r;
    ctl_nxt  = ctl_i;
    if (ctl_i.valid) begin
      case (ctl_i.opcode)
        stc_pkg::OP_ADD: begin
          if (!ctl_i.done && free) begin
            slot_nxt     = key_i;
            ctl_nxt.done = 1'b1;
            ctl_nxt.hit  = 1'b1;
          end
        end
        stc_pkg::OP_REMOVE: begin
          if (match) begin
            slot_nxt    = '0;
            ctl_nxt.hit = 1'b1;
          end
        end
        stc_pkg::OP_REPLACE: begin
          if (!ctl_i.done && match) begin
            slot_nxt     = nv_i;
            ctl_nxt.done = 1'b1;
            ctl_nxt.hit  = 1'b1;
          end
        end
        stc_pkg::OP_CONTAINS: begin
          if (match) begin
            ctl_nxt.hit = 1'b1;
          end
        end
        stc_pkg::OP_CLEAR: begin
          slot_nxt = '0;
        end
        default: begin
        end
      endcase
    end
    cnt_nxt = cnt_i + CNT_W'(slot_nxt != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      ctl_r  <= '0;
    end else if (en) begin
      slot_r <= slot_nxt;
      ctl_r  <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      key_r <= key_i;
      nv_r  <= nv_i;
      cnt_r <= cnt_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign key_o = key_r;
  assign nv_o  = nv_r;
  assign cnt_o = cnt_r;

endmodule

// ===== design/slot_table_cam.sv =====
// Channel  Ports                      Contents (lowest bit first)
// in       in_tvalid/tready/tdata/    tdata: key[31:0], new_value[63:32]
//          tuser                      tuser: opcode[2:0]
// out      out_tvalid/tready/tdata    tdata: hit[0], occupied[9:1], is_empty[10]
//
// One word enters per cycle while in_tready is high; each walks the row of
// ENTRIES cells, one cell per cycle unless frozen; the result is registered.
// Reset empties every slot at once; no clearing pass is needed.
// A stalled output freezes the whole row and drops in_tready until it drains.
module slot_table_cam #(
  parameter int ENTRIES   = stc_pkg::ENTRIES_DEF,
  parameter int KEY_WIDTH = stc_pkg::KEY_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // key[31:0], new_value[63:32]
  input  logic [2:0]  in_tuser,   // opcode[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // hit[0], occupied[9:1], is_empty[10], zero
);

  localparam int CNT_W = $clog2(ENTRIES + 1);

  stc_pkg::ctl_t        ch_ctl [ENTRIES+1];
  logic [KEY_WIDTH-1:0] ch_key [ENTRIES+1];
  logic [KEY_WIDTH-1:0] ch_nv  [ENTRIES+1];
  logic [CNT_W-1:0]     ch_cnt [ENTRIES+1];

  logic                     en;
  logic                     out_valid_r;
  logic                     out_hit_r;
  logic [stc_pkg::OCC_W-1:0] out_occ_r;
  logic                     out_empty_r;
  stc_pkg::ctl_t            tail;

  assign tail      = ch_ctl[ENTRIES];
  assign en        = !(tail.valid && out_valid_r && !out_tready);
  assign in_tready = en;

  assign ch_ctl[0] = {in_tvalid, in_tuser, 1'b0, 1'b0};

  assign ch_key[0] = KEY_WIDTH'(in_tdata[stc_pkg::FIELD_W-1:0]);
  assign ch_nv[0]  = KEY_WIDTH'(in_tdata[2*stc_pkg::FIELD_W-1:stc_pkg::FIELD_W]);
  assign ch_cnt[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    stc_cell #(
      .KEY_WIDTH(KEY_WIDTH),
      .CNT_W    (CNT_W)
    ) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .en   (en),
      .ctl_i(ch_ctl[i]),
      .key_i(ch_key[i]),
      .nv_i (ch_nv[i]),
      .cnt_i(ch_cnt[i]),
      .ctl_o(ch_ctl[i+1]),
      .key_o(ch_key[i+1]),
      .nv_o (ch_nv[i+1]),
      .cnt_o(ch_cnt[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (tail.valid && en) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tail.valid && en) begin
      out_hit_r   <= tail.hit;
      out_occ_r   <= stc_pkg::OCC_W'(ch_cnt[ENTRIES]);
      out_empty_r <= (ch_cnt[ENTRIES] == '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_empty_r, out_occ_r, out_hit_r};

endmodule
